/* hdl/sedrgb_pkg.sv */
// ----------------------------------------------------------------------------
// sedrgb_pkg: shared types and constants of the RGB555 error diffusion block
// Entry layout of the error stores, register indexes and the small helper
// functions for saturation and the three-way bank interleave.
// ----------------------------------------------------------------------------
package sedrgb_pkg;

   localparam int NUM_CH         = 3;
   localparam int CH_W           = 16;
   localparam int TAG_W          = 16;
   localparam int NUM_BANKS      = 3;
   localparam int CSR_INDEX_W    = 4;
   localparam int CSR_DATA_W     = 12;
   localparam int LINE_WIDTH_W   = 11;
   localparam int FRAME_HEIGHT_W = 12;

   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RESET   = 11'd720;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd576;

   localparam logic [TAG_W-1:0] TAG_STALE = 16'hFFFE;

   localparam logic [15:0] DIV3_MUL   = 16'hAAAB;
   localparam int          DIV3_SHIFT = 17;

   localparam logic [7:0] QUANT_MASK = 8'hF8;
   localparam logic [7:0] QUANT_BIAS = 8'h04;
   localparam logic [7:0] PIXEL_MAX  = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH   = 4'd0,
      CSR_FRAME_HEIGHT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [TAG_W-1:0]             tag;
      logic [NUM_CH-1:0][CH_W-1:0]  acc;
   } entry_type;

   function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] acc,
                                                input logic [CH_W-1:0] inc);
      logic [CH_W:0] total;
      total = {acc[CH_W-1], acc} + {inc[CH_W-1], inc};
      if (total[CH_W] != total[CH_W-1]) begin
         return total[CH_W] ? {1'b1, {(CH_W-1){1'b0}}} : {1'b0, {(CH_W-1){1'b1}}};
      end
      return total[CH_W-1:0];
   endfunction

   function automatic logic [1:0] bank_of(input logic [1:0] rem, input logic [1:0] offset);
      logic [2:0] s;
      s = {1'b0, rem} + {1'b0, offset};
      if (s >= 3'(NUM_BANKS)) begin
         s = s - 3'(NUM_BANKS);
      end
      return s[1:0];
   endfunction

   function automatic logic [1:0] offset_of(input logic [1:0] bank, input logic [1:0] rem);
      logic [2:0] s;
      s = {1'b0, bank} + 3'(NUM_BANKS) - {1'b0, rem};
      if (s >= 3'(NUM_BANKS)) begin
         s = s - 3'(NUM_BANKS);
      end
      return s[1:0];
   endfunction

endpackage

/* hdl/serpentine_error_diffusion_rgb555_top.sv */
// ----------------------------------------------------------------------------
// serpentine_error_diffusion_rgb555_top: serpentine RGB888 to RGB555 dither
// Each input beat is registered in the s1 stage, then in the output register.
// Throughput: one pixel per clock while the output is not stalled, set by the
// error feedback from one pixel to the next through the store write bypass.
// Reset: a clearing pass sweeps the error stores; the input stalls during it,
// register writes still go in.
// ----------------------------------------------------------------------------
module serpentine_error_diffusion_rgb555_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_red_in,
   input  logic [7:0]                         req_green_in,
   input  logic [7:0]                         req_blue_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [14:0]                        rsp_pixel_word,
   output logic [9:0]                         rsp_column,
   output logic                               rsp_end_of_row,
   output logic                               rsp_end_of_frame,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sedrgb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sedrgb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sedrgb_pkg::*;

   localparam int SLOTS  = MAX_WIDTH + 2;
   localparam int DEPTH  = (SLOTS + NUM_BANKS - 1) / NUM_BANKS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = $clog2(MAX_WIDTH + 1);
   localparam int CNT_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [LINE_WIDTH_W-1:0]   line_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;

   logic                clr_active_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;

   logic [CNT_W-1:0]          col_cnt_ff, col_cnt_in;
   logic [FRAME_HEIGHT_W-1:0] row_cnt_ff, row_cnt_in;
   logic                      rtl_ff, rtl_in;
   logic [TAG_W-1:0]          gen_ff, gen_in;

   logic [POS_W-1:0]          w_eff;
   logic [CNT_W-1:0]          wm1, k, col;
   logic [FRAME_HEIGHT_W-1:0] h_m1;
   logic                      eor, eof;
   logic [31:0]               div3_prod;
   logic [ADDR_W-1:0]         qb;
   logic [1:0]                rb;
   logic [ADDR_W-1:0]         rd_addr [NUM_BANKS];

   logic accept, s1_adv;

   logic                s1_valid_ff;
   logic [7:0]          s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [ADDR_W-1:0]   s1_addr_ff [NUM_BANKS];
   logic [1:0]          s1_rb_ff;
   logic                s1_rtl_ff;
   logic [TAG_W-1:0]    s1_gen_ff;
   logic [9:0]          s1_col_ff;
   logic                s1_eor_ff, s1_eof_ff;

   entry_type           rd_data  [2][NUM_BANKS];
   entry_type           fwd      [2][NUM_BANKS];
   logic                byp_en_ff   [2][NUM_BANKS];
   logic [ADDR_W-1:0]   byp_addr_ff [2][NUM_BANKS];
   entry_type           byp_data_ff [2][NUM_BANKS];

   logic                wr_en   [2][NUM_BANKS];
   logic [ADDR_W-1:0]   wr_addr [NUM_BANKS];
   entry_type           wr_data [2][NUM_BANKS];

   logic                cur_x, fol_x;
   logic [1:0]          b_ix, b_ahead;
   entry_type           cur_ix_e, cur_ah_e;
   logic                cur_ix_ok, cur_ah_ok;
   logic [7:0]          src [NUM_CH];
   logic signed [CH_W-1:0] cur_acc, shifted;
   logic signed [13:0]  sum, err;
   logic [7:0]          p, qv;
   logic [CH_W-1:0]     e1 [NUM_CH];
   logic [CH_W-1:0]     e3 [NUM_CH];
   logic [CH_W-1:0]     e5 [NUM_CH];
   logic [CH_W-1:0]     e7 [NUM_CH];
   logic [4:0]          q5 [NUM_CH];
   entry_type           cur_new;
   entry_type           fol_new [NUM_BANKS];
   logic [1:0]          offs;
   logic [CH_W-1:0]     base_acc, inc;

   logic                rsp_valid_ff;
   logic [14:0]         rsp_pixel_word_ff;
   logic [9:0]          rsp_column_ff;
   logic                rsp_end_of_row_ff, rsp_end_of_frame_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_data[LINE_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // Position of the next pixel, taken from the counters and the live registers.
   always_comb begin
      if (line_width_ff == '0) begin
         w_eff = POS_W'(1);
      end else if (32'(line_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = POS_W'(MAX_WIDTH);
      end else begin
         w_eff = POS_W'(line_width_ff);
      end
      wm1  = CNT_W'(w_eff - POS_W'(1));
      k    = (col_cnt_ff > wm1) ? wm1 : col_cnt_ff;
      col  = rtl_ff ? (wm1 - k) : k;
      h_m1 = (frame_height_ff == '0) ? '0 : (frame_height_ff - FRAME_HEIGHT_W'(1));
      eor  = (k == wm1);
      eof  = eor && (row_cnt_ff >= h_m1);
      div3_prod = 32'(col) * 32'(DIV3_MUL);
      qb = ADDR_W'(div3_prod >> DIV3_SHIFT);
      rb = 2'(32'(col) - 32'(qb) * 32'(NUM_BANKS));
      for (int b = 0; b < NUM_BANKS; b++) begin
         rd_addr[b] = (2'(b) >= rb) ? qb : (qb + ADDR_W'(1));
      end
   end

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr_active_ff || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      rtl_in     = rtl_ff;
      gen_in     = gen_ff;
      if (accept) begin
         if (eof) begin
            col_cnt_in = '0;
            row_cnt_in = '0;
            rtl_in     = 1'b0;
            gen_in     = gen_ff + TAG_W'(2);
         end else if (eor) begin
            col_cnt_in = '0;
            row_cnt_in = row_cnt_ff + FRAME_HEIGHT_W'(1);
            rtl_in     = !rtl_ff;
            gen_in     = gen_ff + TAG_W'(1);
         end else begin
            col_cnt_in = k + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         rtl_ff     <= 1'b0;
         gen_ff     <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         rtl_ff     <= rtl_in;
         gen_ff     <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_red_ff   <= req_red_in;
         s1_green_ff <= req_green_in;
         s1_blue_ff  <= req_blue_in;
         s1_addr_ff  <= rd_addr;
         s1_rb_ff    <= rb;
         s1_rtl_ff   <= rtl_ff;
         s1_gen_ff   <= gen_ff;
         s1_col_ff   <= 10'(col);
         s1_eor_ff   <= eor;
         s1_eof_ff   <= eof;
      end
   end

   // Two error stores, each split into three banks by slot modulo three, so
   // one pixel reaches its three neighboring slots with one access per bank.
   for (genvar x = 0; x < 2; x++) begin : g_store
      for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
         entry_type mem_ff [DEPTH];
         entry_type rd_ff;

         always_ff @(posedge clock) begin
            if (wr_en[x][b]) begin
               mem_ff[wr_addr[b]] <= wr_data[x][b];
            end
            if (accept) begin
               rd_ff <= mem_ff[rd_addr[b]];
            end
         end

         assign rd_data[x][b] = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int x = 0; x < 2; x++) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            if (reset) begin
               byp_en_ff[x][b] <= 1'b0;
            end else if (wr_en[x][b]) begin
               byp_en_ff[x][b] <= 1'b1;
            end
            if (wr_en[x][b]) begin
               byp_addr_ff[x][b] <= wr_addr[b];
               byp_data_ff[x][b] <= wr_data[x][b];
            end
         end
      end
   end

   assign src[0] = s1_red_ff;
   assign src[1] = s1_green_ff;
   assign src[2] = s1_blue_ff;

   // Entries carry the row generation that wrote them; a stale tag reads as zero.
   always_comb begin
      for (int x = 0; x < 2; x++) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            if (byp_en_ff[x][b] && (byp_addr_ff[x][b] == s1_addr_ff[b])) begin
               fwd[x][b] = byp_data_ff[x][b];
            end else begin
               fwd[x][b] = rd_data[x][b];
            end
         end
      end

      cur_x    = s1_gen_ff[0];
      fol_x    = !s1_gen_ff[0];
      b_ix     = bank_of(s1_rb_ff, 2'd1);
      b_ahead  = bank_of(s1_rb_ff, s1_rtl_ff ? 2'd0 : 2'd2);
      cur_ix_e = fwd[cur_x][b_ix];
      cur_ah_e = fwd[cur_x][b_ahead];
      cur_ix_ok = (cur_ix_e.tag == s1_gen_ff) || (cur_ix_e.tag == s1_gen_ff - TAG_W'(1));
      cur_ah_ok = (cur_ah_e.tag == s1_gen_ff) || (cur_ah_e.tag == s1_gen_ff - TAG_W'(1));

      cur_new.tag = s1_gen_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         cur_acc = cur_ix_ok ? $signed(cur_ix_e.acc[c]) : '0;
         shifted = cur_acc >>> 4;
         sum = $signed({6'b0, src[c]}) + $signed(shifted[13:0]);
         if (sum < 0) begin
            p = '0;
         end else if (sum > $signed({6'b0, PIXEL_MAX})) begin
            p = PIXEL_MAX;
         end else begin
            p = sum[7:0];
         end
         qv = (p & QUANT_MASK) | QUANT_BIAS;
         err = sum - $signed({6'b0, qv});
         q5[c] = qv[7:3];
         e1[c] = {{(CH_W-14){err[13]}}, err};
         e3[c] = (e1[c] << 1) + e1[c];
         e5[c] = (e1[c] << 2) + e1[c];
         e7[c] = (e1[c] << 3) - e1[c];
         cur_new.acc[c] = sat_add(cur_ah_ok ? cur_ah_e.acc[c] : '0, e7[c]);
      end

      for (int b = 0; b < NUM_BANKS; b++) begin
         offs = offset_of(2'(b), s1_rb_ff);
         fol_new[b].tag = s1_gen_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            base_acc = (fwd[fol_x][b].tag == s1_gen_ff) ? fwd[fol_x][b].acc[c] : '0;
            if (offs == 2'd1) begin
               inc = e5[c];
            end else if (offs == 2'd0) begin
               inc = s1_rtl_ff ? e1[c] : e3[c];
            end else begin
               inc = s1_rtl_ff ? e3[c] : e1[c];
            end
            fol_new[b].acc[c] = sat_add(base_acc, inc);
         end
      end
   end

   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         wr_addr[b] = clr_active_ff ? clr_addr_ff : s1_addr_ff[b];
      end
      for (int x = 0; x < 2; x++) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            if (clr_active_ff) begin
               wr_en[x][b]   = 1'b1;
               wr_data[x][b] = '{tag: TAG_STALE, acc: '0};
            end else begin
               if (x == int'(fol_x)) begin
                  wr_en[x][b]   = s1_adv;
                  wr_data[x][b] = fol_new[b];
               end else begin
                  wr_en[x][b]   = s1_adv && (2'(b) == b_ahead);
                  wr_data[x][b] = cur_new;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pixel_word_ff   <= {q5[0], q5[1], q5[2]};
         rsp_column_ff       <= s1_col_ff;
         rsp_end_of_row_ff   <= s1_eor_ff;
         rsp_end_of_frame_ff <= s1_eof_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_word   = rsp_pixel_word_ff;
   assign rsp_column       = rsp_column_ff;
   assign rsp_end_of_row   = rsp_end_of_row_ff;
   assign rsp_end_of_frame = rsp_end_of_frame_ff;

endmodule

/* sim/tb_serpentine_error_diffusion_rgb555_top.sv */
// ----------------------------------------------------------------------------
// tb_serpentine_error_diffusion_rgb555_top: self-checking bench for the dither
// Streams pixels through the serpentine error diffusion block and checks
// every result beat against an in-bench predictor of the quantizer and its
// error stores. Directed tests cover extremes, degenerate and shrunk
// geometry, and ignored register indexes. Random traffic follows, then long
// dark and bright frames that drive the accumulators into saturation.
// ----------------------------------------------------------------------------
module tb_serpentine_error_diffusion_rgb555_top;
   import sedrgb_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int SLOTS         = MAX_WIDTH + 2;
   localparam int ACC_MAX       = 32767;
   localparam int ACC_MIN       = -32768;
   localparam int WEIGHT_AHEAD  = 7;
   localparam int WEIGHT_BEHIND = 3;
   localparam int WEIGHT_BELOW  = 5;
   localparam int WEIGHT_DIAG   = 1;
   localparam int WIDTH_RAW_MAX = (1 << LINE_WIDTH_W) - 1;
   localparam int HEIGHT_RAW_MAX = (1 << FRAME_HEIGHT_W) - 1;

   localparam logic [CSR_INDEX_W-1:0] UNMAPPED_INDEX_LO = 4'h2;
   localparam logic [CSR_INDEX_W-1:0] UNMAPPED_INDEX_HI = 4'hF;

   localparam int STREAM_ITEMS  = 465;
   localparam int SAT_WIDTH     = 96;
   localparam int DARK_ROWS     = 480;
   localparam int BRIGHT_ROWS   = 720;
   localparam int DRAIN_CYCLES  = 8;
   localparam int TIMEOUT_UNITS = 50_000_000;

   typedef struct packed {
      logic [14:0] word;
      logic [9:0]  column;
      logic        end_of_row;
      logic        end_of_frame;
   } dither_result_t;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } register_beat_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_red_in = '0;
   logic [7:0]             req_green_in = '0;
   logic [7:0]             req_blue_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [14:0]            rsp_pixel_word;
   logic [9:0]             rsp_column;
   logic                   rsp_end_of_row;
   logic                   rsp_end_of_frame;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [LINE_WIDTH_W-1:0]   width_reg = LINE_WIDTH_RESET;
   logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RESET;
   int err_this_row [NUM_CH][SLOTS];
   int err_next_row [NUM_CH][SLOTS];
   int column_count = 0;
   int row_count = 0;
   bit reversed = 1'b0;

   dither_result_t expected_pixels [$];
   register_beat_t register_writes [$];
   int gap_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int results_seen = 0;

   serpentine_error_diffusion_rgb555_top #(
      .MAX_WIDTH(MAX_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_word(rsp_pixel_word),
      .rsp_column(rsp_column),
      .rsp_end_of_row(rsp_end_of_row),
      .rsp_end_of_frame(rsp_end_of_frame),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic int clip16(input int v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   task automatic dither_pixel(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue);
      int w, h, k, col, ix, ahead, behind, sum, level, quant, err, c, s;
      logic [7:0] channel [NUM_CH];
      logic [4:0] code [NUM_CH];
      dither_result_t res;
      channel[0] = red;
      channel[1] = green;
      channel[2] = blue;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < 1) h = 1;
      k = (column_count > w - 1) ? w - 1 : column_count;
      col = reversed ? w - 1 - k : k;
      ix = col + 1;
      ahead = reversed ? ix - 1 : ix + 1;
      behind = reversed ? ix + 1 : ix - 1;
      for (c = 0; c < NUM_CH; c++) begin
         sum = int'(channel[c]) + (err_this_row[c][ix] >>> 4);
         if (sum > int'(PIXEL_MAX)) level = int'(PIXEL_MAX);
         else if (sum < 0) level = 0;
         else level = sum;
         quant = (level & int'(QUANT_MASK)) | int'(QUANT_BIAS);
         err = sum - quant;
         err_this_row[c][ahead] = clip16(err_this_row[c][ahead] + WEIGHT_AHEAD * err);
         err_next_row[c][behind] = clip16(err_next_row[c][behind] + WEIGHT_BEHIND * err);
         err_next_row[c][ix] = clip16(err_next_row[c][ix] + WEIGHT_BELOW * err);
         err_next_row[c][ahead] = clip16(err_next_row[c][ahead] + WEIGHT_DIAG * err);
         code[c] = quant[7:3];
      end
      res.word = {code[0], code[1], code[2]};
      res.column = col[9:0];
      res.end_of_row = (k == w - 1);
      res.end_of_frame = res.end_of_row && (row_count >= h - 1);
      expected_pixels.push_back(res);
      if (res.end_of_row) begin
         for (c = 0; c < NUM_CH; c++) begin
            for (s = 0; s < SLOTS; s++) begin
               err_this_row[c][s] = res.end_of_frame ? 0 : err_next_row[c][s];
               err_next_row[c][s] = 0;
            end
         end
         column_count = 0;
         row_count = res.end_of_frame ? 0 : (row_count + 1) % (HEIGHT_RAW_MAX + 1);
         reversed = res.end_of_frame ? 1'b0 : !reversed;
      end else begin
         column_count = k + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("beat %0d: %s is %0d, expected %0d", results_seen, what, got, want);
      end
   endtask

   always @(posedge clock) begin : check_results
      dither_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected beat, pixel_word", rsp_pixel_word, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_word !== want.word)
               report_mismatch("pixel_word", rsp_pixel_word, want.word);
            if (rsp_column !== want.column)
               report_mismatch("column", rsp_column, want.column);
            if (rsp_end_of_row !== want.end_of_row)
               report_mismatch("end_of_row", rsp_end_of_row, want.end_of_row);
            if (rsp_end_of_frame !== want.end_of_frame)
               report_mismatch("end_of_frame", rsp_end_of_frame, want.end_of_frame);
         end
         results_seen++;
      end
   end

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= red;
      req_green_in <= green;
      req_blue_in <= blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      dither_pixel(red, green, blue);
   endtask

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_pixel();
      send_pixel(random_channel(), random_channel(), random_channel());
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   function automatic void queue_write(input logic [CSR_INDEX_W-1:0] index,
                                       input logic [CSR_DATA_W-1:0] data);
      register_beat_t beat;
      beat.index = index;
      beat.data = data;
      register_writes.push_back(beat);
   endfunction

   // Registers change only once the block holds no pixel in flight.
   task automatic program_registers();
      register_beat_t beat;
      wait_for_results();
      while (register_writes.size() != 0) begin
         beat = register_writes.pop_front();
         csr_valid <= 1'b1;
         csr_index <= beat.index;
         csr_data <= beat.data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (beat.index == CSR_LINE_WIDTH) width_reg = beat.data[LINE_WIDTH_W-1:0];
         else if (beat.index == CSR_FRAME_HEIGHT) height_reg = beat.data;
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_width_data();
      int w;
      case ($urandom_range(0, 9))
         0: w = 0;
         1: w = $urandom_range(MAX_WIDTH + 1, WIDTH_RAW_MAX);
         default: w = $urandom_range(1, 16);
      endcase
      return {1'($urandom_range(0, 1)), LINE_WIDTH_W'(w)};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_height_data();
      if ($urandom_range(0, 7) == 0) return CSR_DATA_W'($urandom_range(0, HEIGHT_RAW_MAX));
      return CSR_DATA_W'($urandom_range(0, 6));
   endfunction

   // Shrinking the height to one row makes the current row the last of the frame.
   task automatic finish_frame();
      queue_write(CSR_FRAME_HEIGHT, 12'd1);
      program_registers();
      while (column_count != 0 || row_count != 0 || reversed) send_random_pixel();
   endtask

   task automatic test_extremes();
      queue_write(CSR_LINE_WIDTH, 12'h803);
      queue_write(CSR_FRAME_HEIGHT, 12'd2);
      program_registers();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd128);
      send_pixel(8'd3, 8'd4, 8'd252);
      send_pixel(8'd127, 8'd128, 8'd251);
      send_pixel(8'd0, 8'd255, 8'd7);
   endtask

   task automatic test_degenerate_sizes();
      queue_write(CSR_LINE_WIDTH, 12'd0);
      queue_write(CSR_FRAME_HEIGHT, 12'd0);
      program_registers();
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
   endtask

   task automatic test_shrunk_registers();
      queue_write(CSR_LINE_WIDTH, 12'hFFF);
      queue_write(CSR_FRAME_HEIGHT, 12'hFFF);
      queue_write(UNMAPPED_INDEX_HI, 12'h001);
      queue_write(UNMAPPED_INDEX_LO, 12'hFFF);
      program_registers();
      repeat (5) send_random_pixel();
      queue_write(CSR_LINE_WIDTH, 12'd3);
      program_registers();
      repeat (4) send_random_pixel();
      queue_write(CSR_FRAME_HEIGHT, 12'd2);
      program_registers();
      repeat (3) send_random_pixel();
   endtask

   task automatic test_full_width();
      finish_frame();
      queue_write(CSR_LINE_WIDTH, {1'($urandom_range(0, 1)),
                                   LINE_WIDTH_W'($urandom_range(MAX_WIDTH, WIDTH_RAW_MAX))});
      queue_write(CSR_FRAME_HEIGHT, 12'd1);
      program_registers();
      repeat (MAX_WIDTH) send_random_pixel();
   endtask

   task automatic test_random_stream(input int count);
      int sent, burst, writes;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 3) == 0) begin
            writes = $urandom_range(1, 2);
            repeat (writes) begin
               case ($urandom_range(0, 2))
                  0: queue_write(CSR_LINE_WIDTH, random_width_data());
                  1: queue_write(CSR_FRAME_HEIGHT, random_height_data());
                  default: queue_write(CSR_INDEX_W'($urandom_range(UNMAPPED_INDEX_LO,
                                                                   UNMAPPED_INDEX_HI)),
                                       CSR_DATA_W'($urandom));
               endcase
            end
            program_registers();
         end
         burst = $urandom_range(1, 24);
         repeat (burst) send_random_pixel();
         sent += burst;
      end
   endtask

   // Near-constant black or white leaves a residue at every pixel, which piles
   // up over many rows until the accumulators clip.
   task automatic test_saturation(input bit bright);
      logic [7:0] shade [NUM_CH];
      int c;
      finish_frame();
      queue_write(CSR_LINE_WIDTH, 12'(SAT_WIDTH));
      queue_write(CSR_FRAME_HEIGHT, 12'(bright ? BRIGHT_ROWS : DARK_ROWS));
      program_registers();
      repeat (SAT_WIDTH * (bright ? BRIGHT_ROWS : DARK_ROWS)) begin
         for (c = 0; c < NUM_CH; c++) begin
            if ($urandom_range(0, 15) == 0) shade[c] = bright ? 8'd254 : 8'd1;
            else shade[c] = bright ? 8'd255 : 8'd0;
         end
         send_pixel(shade[0], shade[1], shade[2]);
      end
   endtask

   initial begin
      gap_pct = 19;
      stall_pct = 83;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_degenerate_sizes();
      test_shrunk_registers();
      test_random_stream(STREAM_ITEMS);
      gap_pct = 83;
      stall_pct = 19;
      test_full_width();
      test_random_stream(STREAM_ITEMS);
      gap_pct = 0;
      stall_pct = 0;
      test_saturation(1'b0);
      test_saturation(1'b1);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_UNITS;
      $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
hdl/sedrgb_pkg.sv
hdl/serpentine_error_diffusion_rgb555_top.sv
sim/tb_serpentine_error_diffusion_rgb555_top.sv
